### rtl/stbx_pkg.sv
`default_nettype none
package stbx_pkg;

  // Machine geometry
  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned VAR_BYTES   = 512;
  localparam int unsigned INSTR_BYTES = 3;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned DEPTH_W = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SP_W    = $clog2(STACK_DEPTH);
  localparam int unsigned VA_W    = $clog2(VAR_BYTES);
  localparam int unsigned QP_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QC_W    = $clog2(QUEUE_DEPTH + 1);

  // Opcodes
  localparam logic [4:0] OP_NOP        = 5'd0;
  localparam logic [4:0] OP_PUSH_CONST = 5'd1;
  localparam logic [4:0] OP_PUSH_VAR   = 5'd2;
  localparam logic [4:0] OP_POP        = 5'd3;
  localparam logic [4:0] OP_BRZ        = 5'd4;
  localparam logic [4:0] OP_JMP        = 5'd5;
  localparam logic [4:0] OP_CALL       = 5'd6;
  localparam logic [4:0] OP_RET        = 5'd7;
  localparam logic [4:0] OP_HALT       = 5'd8;
  localparam logic [4:0] OP_EQ         = 5'd9;
  localparam logic [4:0] OP_NEQ        = 5'd10;
  localparam logic [4:0] OP_LT         = 5'd11;
  localparam logic [4:0] OP_LTE        = 5'd12;
  localparam logic [4:0] OP_GT         = 5'd13;
  localparam logic [4:0] OP_GTE        = 5'd14;
  localparam logic [4:0] OP_ADD        = 5'd15;
  localparam logic [4:0] OP_SUB        = 5'd16;
  localparam logic [4:0] OP_MUL        = 5'd17;
  localparam logic [4:0] OP_DIV        = 5'd18;
  localparam logic [4:0] OP_MOD        = 5'd19;
  localparam logic [4:0] OP_POW        = 5'd20;
  localparam logic [4:0] OP_SHL        = 5'd21;
  localparam logic [4:0] OP_SHR        = 5'd22;
  localparam logic [4:0] OP_BOR        = 5'd23;
  localparam logic [4:0] OP_BAND       = 5'd24;
  localparam logic [4:0] OP_LOR        = 5'd25;
  localparam logic [4:0] OP_LAND       = 5'd26;

  // Status codes
  localparam logic [2:0] STAT_OK    = 3'd0;
  localparam logic [2:0] STAT_HALT  = 3'd1;
  localparam logic [2:0] STAT_OVER  = 3'd2;
  localparam logic [2:0] STAT_UNDER = 3'd3;
  localparam logic [2:0] STAT_BADOP = 3'd4;
  localparam logic [2:0] STAT_DIVZ  = 3'd5;

  typedef enum logic [3:0] {
    CL_NOP,
    CL_JMP,
    CL_HALT,
    CL_BAD,
    CL_PUSHC,
    CL_PUSHV,
    CL_POP,
    CL_BRZ,
    CL_CALL,
    CL_RET,
    CL_BINOP
  } cls_e;

  // Classified instruction as queued between front and back
  typedef struct packed {
    cls_e        cls;
    logic [4:0]  op;
    logic [15:0] opd;
    logic [15:0] fall;
  } cmd_t;

  typedef struct packed {
    logic [15:0] top_value;
    logic [15:0] next_pc;
    logic [2:0]  status;
  } result_t;

endpackage
`default_nettype wire

### rtl/stbx_ram.sv
`default_nettype none
module stbx_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

### rtl/stbx_front.sv
`default_nettype none
module stbx_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [4:0]       req_type_i,
  input  wire logic [15:0]      operand_i,
  input  wire logic [15:0]      pc_i,
  input  wire logic             clearing_i,
  output logic                  cmd_valid_o,
  output stbx_pkg::cmd_t        cmd_o,
  input  wire logic             cmd_pop_i
);
  import stbx_pkg::*;

  cmd_t            q_mem [QUEUE_DEPTH];
  logic [QP_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QC_W-1:0] cnt_q, cnt_d;
  logic            push;
  cmd_t            cmd_new;

  // Classify the opcode
  always_comb begin
    cmd_new.op   = req_type_i;
    cmd_new.opd  = operand_i;
    cmd_new.fall = pc_i + 16'(INSTR_BYTES);
    case (req_type_i)
      OP_NOP:        cmd_new.cls = CL_NOP;
      OP_PUSH_CONST: cmd_new.cls = CL_PUSHC;
      OP_PUSH_VAR:   cmd_new.cls = CL_PUSHV;
      OP_POP:        cmd_new.cls = CL_POP;
      OP_BRZ:        cmd_new.cls = CL_BRZ;
      OP_JMP:        cmd_new.cls = CL_JMP;
      OP_CALL:       cmd_new.cls = CL_CALL;
      OP_RET:        cmd_new.cls = CL_RET;
      OP_HALT:       cmd_new.cls = CL_HALT;
      default:       cmd_new.cls = (req_type_i > OP_LAND) ? CL_BAD : CL_BINOP;
    endcase
  end

  assign in_ready_o  = (cnt_q != QC_W'(QUEUE_DEPTH)) && !clearing_i;
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = q_mem[rd_q];

  // Advance queue pointers
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (cmd_pop_i) begin
      rd_d = (rd_q == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !cmd_pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && cmd_pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Hold queued entries
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_q] <= cmd_new;
    end
  end

endmodule
`default_nettype wire

### rtl/stbx_back.sv
`default_nettype none
module stbx_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cmd_valid_i,
  input  stbx_pkg::cmd_t         cmd_i,
  output logic                   cmd_pop_o,
  output logic                   clearing_o,
  output logic                   res_valid_o,
  input  wire logic              res_ready_i,
  output stbx_pkg::result_t      res_o
);
  import stbx_pkg::*;

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DISP  = 4'd2;
  localparam logic [3:0] S_VRD1  = 4'd3;
  localparam logic [3:0] S_VRD2  = 4'd4;
  localparam logic [3:0] S_POPRD = 4'd5;
  localparam logic [3:0] S_POPW2 = 4'd6;
  localparam logic [3:0] S_RETRD = 4'd7;
  localparam logic [3:0] S_BINRD = 4'd8;
  localparam logic [3:0] S_ALU   = 4'd9;
  localparam logic [3:0] S_ITER  = 4'd10;
  localparam logic [3:0] S_WB    = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  logic [3:0]         state_q, state_d;
  cmd_t               cur_q, cur_d;
  logic [DEPTH_W-1:0] depth_q, depth_d, rdepth_q, rdepth_d;
  logic [15:0]        top_q, top_d, res_q, res_d, opa_q, opa_d, opb_q, opb_d;
  logic [15:0]        acc_q, acc_d, base_q, base_d, exp_q, exp_d;
  logic [15:0]        quo_q, quo_d, rem_q, rem_d, next_q, next_d;
  logic [7:0]         lo_q, lo_d;
  logic [3:0]         cnt_q, cnt_d;
  logic [VA_W-1:0]    clr_q, clr_d;
  logic [2:0]         stat_q, stat_d;
  logic               out_valid_q, out_valid_d;
  result_t            out_q, out_d;

  // RAM controls
  logic               dwe, rwe, vwe;
  logic [SP_W-1:0]    dwaddr, draddr, rwaddr, rraddr;
  logic [15:0]        dwdata, rwdata, drdata, rrdata;
  logic [VA_W-1:0]    vwaddr, vraddr;
  logic [7:0]         vwdata, vrdata;

  // Helpers
  logic [DEPTH_W-1:0] dm1, dm2, rm1;
  logic [15:0]        opd_p1, pm_acc, pm_base, wb_val;
  logic               lo_in, hi_in;
  logic [16:0]        rem_sh, rem_diff;
  logic               rem_ge;

  assign dm1     = depth_q - DEPTH_W'(1);
  assign dm2     = depth_q - DEPTH_W'(2);
  assign rm1     = rdepth_q - DEPTH_W'(1);
  assign opd_p1  = cur_q.opd + 16'd1;
  assign lo_in   = cur_q.opd < 16'(VAR_BYTES);
  assign hi_in   = ({1'b0, cur_q.opd} + 17'd1) < 17'(VAR_BYTES);
  assign pm_acc  = acc_q * base_q;
  assign pm_base = base_q * base_q;
  assign rem_sh  = {rem_q, quo_q[15]};
  assign rem_diff = rem_sh - {1'b0, opb_q};
  assign rem_ge  = (rem_sh >= {1'b0, opb_q});

  always_comb begin
    case (cur_q.op)
      OP_DIV:  wb_val = quo_q;
      OP_MOD:  wb_val = rem_q;
      OP_POW:  wb_val = acc_q;
      default: wb_val = res_q;
    endcase
  end

  assign clearing_o  = (state_q == S_CLR);
  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    depth_d     = depth_q;
    rdepth_d    = rdepth_q;
    top_d       = top_q;
    res_d       = res_q;
    opa_d       = opa_q;
    opb_d       = opb_q;
    acc_d       = acc_q;
    base_d      = base_q;
    exp_d       = exp_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    next_d      = next_q;
    lo_d        = lo_q;
    cnt_d       = cnt_q;
    clr_d       = clr_q;
    stat_d      = stat_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    cmd_pop_o   = 1'b0;
    dwe    = 1'b0;
    dwaddr = depth_q[SP_W-1:0];
    dwdata = cur_q.opd;
    draddr = dm2[SP_W-1:0];
    rwe    = 1'b0;
    rwaddr = rdepth_q[SP_W-1:0];
    rwdata = cur_q.fall;
    rraddr = rm1[SP_W-1:0];
    vwe    = 1'b0;
    vwaddr = cur_q.opd[VA_W-1:0];
    vwdata = res_q[7:0];
    vraddr = cur_q.opd[VA_W-1:0];

    // Drop a transferred result
    if (out_valid_q && res_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      // Zero variable memory after reset
      S_CLR: begin
        vwe    = 1'b1;
        vwaddr = clr_q;
        vwdata = 8'd0;
        clr_d  = clr_q + 1'b1;
        if (clr_q == VA_W'(VAR_BYTES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cur_d     = cmd_i;
          state_d   = S_DISP;
        end
      end
      S_DISP: begin
        stat_d  = STAT_OK;
        next_d  = cur_q.fall;
        state_d = S_OUT;
        case (cur_q.cls)
          CL_NOP:  ;
          CL_JMP:  next_d = cur_q.opd;
          CL_HALT: stat_d = STAT_HALT;
          CL_BAD:  stat_d = STAT_BADOP;
          CL_PUSHC: begin
            if (depth_q == DEPTH_W'(STACK_DEPTH)) begin
              stat_d = STAT_OVER;
            end else begin
              dwe     = 1'b1;
              depth_d = depth_q + 1'b1;
              top_d   = cur_q.opd;
            end
          end
          CL_PUSHV: begin
            if (depth_q == DEPTH_W'(STACK_DEPTH)) begin
              stat_d = STAT_OVER;
            end else begin
              state_d = S_VRD1;
            end
          end
          CL_POP, CL_BRZ: begin
            if (depth_q == '0) begin
              stat_d = STAT_UNDER;
            end else begin
              res_d   = top_q;
              depth_d = dm1;
              state_d = S_POPRD;
            end
          end
          CL_CALL: begin
            if (rdepth_q == DEPTH_W'(STACK_DEPTH)) begin
              stat_d = STAT_OVER;
            end else begin
              rwe      = 1'b1;
              rdepth_d = rdepth_q + 1'b1;
              next_d   = cur_q.opd;
            end
          end
          CL_RET: begin
            if (rdepth_q == '0) begin
              stat_d = STAT_UNDER;
            end else begin
              rdepth_d = rm1;
              state_d  = S_RETRD;
            end
          end
          CL_BINOP: begin
            if (depth_q < DEPTH_W'(2)) begin
              stat_d = STAT_UNDER;
            end else begin
              state_d = S_BINRD;
            end
          end
          default: stat_d = STAT_BADOP;
        endcase
      end
      // Low byte arrives, request high byte
      S_VRD1: begin
        vraddr  = opd_p1[VA_W-1:0];
        lo_d    = lo_in ? vrdata : 8'd0;
        state_d = S_VRD2;
      end
      S_VRD2: begin
        dwe     = 1'b1;
        dwdata  = {hi_in ? vrdata : 8'd0, lo_q};
        top_d   = dwdata;
        depth_d = depth_q + 1'b1;
        state_d = S_OUT;
      end
      // New top arrives; write low byte or resolve branch
      S_POPRD: begin
        top_d = (depth_q != '0) ? drdata : 16'd0;
        if (cur_q.cls == CL_BRZ) begin
          if (res_q == 16'd0) begin
            next_d = cur_q.opd;
          end
          state_d = S_OUT;
        end else begin
          vwe     = lo_in;
          vwdata  = res_q[7:0];
          state_d = S_POPW2;
        end
      end
      S_POPW2: begin
        vwe     = hi_in;
        vwaddr  = opd_p1[VA_W-1:0];
        vwdata  = res_q[15:8];
        state_d = S_OUT;
      end
      S_RETRD: begin
        next_d  = rrdata;
        state_d = S_OUT;
      end
      S_BINRD: begin
        opa_d   = drdata;
        opb_d   = top_q;
        state_d = S_ALU;
      end
      // Compute the other binops directly, flag divide by zero, or set up an iterative one
      S_ALU: begin
        state_d = S_WB;
        cnt_d   = '0;
        case (cur_q.op)
          OP_EQ:   res_d = {15'd0, opa_q == opb_q};
          OP_NEQ:  res_d = {15'd0, opa_q != opb_q};
          OP_LT:   res_d = {15'd0, opa_q < opb_q};
          OP_LTE:  res_d = {15'd0, opa_q <= opb_q};
          OP_GT:   res_d = {15'd0, opa_q > opb_q};
          OP_GTE:  res_d = {15'd0, opa_q >= opb_q};
          OP_ADD:  res_d = opa_q + opb_q;
          OP_SUB:  res_d = opa_q - opb_q;
          OP_MUL:  res_d = opa_q * opb_q;
          OP_SHL:  res_d = (opb_q >= 16'd16) ? 16'd0 : (opa_q << opb_q[3:0]);
          OP_SHR:  res_d = (opb_q >= 16'd16) ? 16'd0 : (opa_q >> opb_q[3:0]);
          OP_BOR:  res_d = opa_q | opb_q;
          OP_BAND: res_d = opa_q & opb_q;
          OP_LOR:  res_d = {15'd0, (opa_q != 16'd0) || (opb_q != 16'd0)};
          OP_LAND: res_d = {15'd0, (opa_q != 16'd0) && (opb_q != 16'd0)};
          OP_DIV, OP_MOD: begin
            if (opb_q == 16'd0) begin
              stat_d  = STAT_DIVZ;
              state_d = S_OUT;
            end else begin
              rem_d   = 16'd0;
              quo_d   = opa_q;
              state_d = S_ITER;
            end
          end
          OP_POW: begin
            acc_d   = 16'd1;
            base_d  = opa_q;
            exp_d   = opb_q;
            state_d = S_ITER;
          end
          default: res_d = 16'd0;
        endcase
      end
      // One restoring-divide or square-and-multiply step per cycle
      S_ITER: begin
        if (cur_q.op == OP_POW) begin
          if (exp_q[0]) begin
            acc_d = pm_acc;
          end
          base_d = pm_base;
          exp_d  = {1'b0, exp_q[15:1]};
        end else begin
          rem_d = rem_ge ? rem_diff[15:0] : rem_sh[15:0];
          quo_d = {quo_q[14:0], rem_ge};
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 4'd15) begin
          state_d = S_WB;
        end
      end
      S_WB: begin
        dwe     = 1'b1;
        dwaddr  = dm2[SP_W-1:0];
        dwdata  = wb_val;
        top_d   = wb_val;
        depth_d = dm1;
        state_d = S_OUT;
      end
      // Load the output register once it is free
      S_OUT: begin
        if (!out_valid_q || res_ready_i) begin
          out_valid_d     = 1'b1;
          out_d.status    = stat_q;
          out_d.next_pc   = (stat_q == STAT_OK) ? next_q : cur_q.fall;
          out_d.top_value = top_q;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      depth_q     <= '0;
      rdepth_q    <= '0;
      top_q       <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      depth_q     <= depth_d;
      rdepth_q    <= rdepth_d;
      top_q       <= top_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    res_q  <= res_d;
    opa_q  <= opa_d;
    opb_q  <= opb_d;
    acc_q  <= acc_d;
    base_q <= base_d;
    exp_q  <= exp_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    next_q <= next_d;
    lo_q   <= lo_d;
    stat_q <= stat_d;
    out_q  <= out_d;
  end

  stbx_ram #(.WIDTH(16), .DEPTH(STACK_DEPTH)) u_data_stack (
    .clk_i   (clk_i),
    .we_i    (dwe),
    .waddr_i (dwaddr),
    .wdata_i (dwdata),
    .raddr_i (draddr),
    .rdata_o (drdata)
  );

  stbx_ram #(.WIDTH(16), .DEPTH(STACK_DEPTH)) u_return_stack (
    .clk_i   (clk_i),
    .we_i    (rwe),
    .waddr_i (rwaddr),
    .wdata_i (rwdata),
    .raddr_i (rraddr),
    .rdata_o (rrdata)
  );

  stbx_ram #(.WIDTH(8), .DEPTH(VAR_BYTES)) u_var_mem (
    .clk_i   (clk_i),
    .we_i    (vwe),
    .waddr_i (vwaddr),
    .wdata_i (vwdata),
    .raddr_i (vraddr),
    .rdata_o (vrdata)
  );

endmodule
`default_nettype wire

### rtl/stack_bytecode_execute_unit.sv
// Stack bytecode execute unit.
// Slave stream: one instruction per transfer (opcode, operand, pc of the
// instruction). Master stream: one result per instruction (status, next pc,
// top of the data stack after the step, 0 when the stack is empty).
// Instructions are classified and placed in a two-entry queue; the execute
// engine takes them one at a time and owns the data stack, the return stack
// and the byte-wide variable memory, each a registered-read RAM.
// Div, mod and pow run 16 steps of one shared iterator. The engine takes
// the next instruction in the cycle after loading a result, so it never
// works on two instructions at once.
// After reset the engine zeroes all 512 bytes of variable memory, holding
// s_axis_tready low; stacks reset empty.
// While the receiver stalls the result waits in the output register, the
// engine finishes the next instruction and holds, and the queue keeps
// accepting until full.
`default_nettype none
module stack_bytecode_execute_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,   // req_type[4:0], operand[20:5], pc[36:21]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [39:0] m_axis_tdata    // status[2:0], next_pc[18:3], top_value[34:19]
);
  import stbx_pkg::*;

  cmd_t    cmd;
  logic    cmd_valid, cmd_pop, clearing;
  result_t res;

  stbx_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .req_type_i  (s_axis_tdata[4:0]),
    .operand_i   (s_axis_tdata[20:5]),
    .pc_i        (s_axis_tdata[36:21]),
    .clearing_i  (clearing),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  stbx_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .clearing_o  (clearing),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  // Pack the result
  assign m_axis_tdata = {5'd0, res.top_value, res.next_pc, res.status};

endmodule
`default_nettype wire
